[sv/srb_pkg.sv]
// Shared request/response types and codes for the sequence reorder buffer.
`timescale 1ns / 1ps

package srb_pkg;

  // Operation codes carried by a request
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_FATAL = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_STALE     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_FATAL     = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] seq_number;
    logic [15:0] in_length;
    logic [31:0] in_descriptor;
  } srb_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wake_reader;
    logic [15:0] out_length;
    logic [31:0] out_descriptor;
    logic [31:0] out_seq;
  } srb_out_t;

endpackage

[sv/srb_slot_mem.sv]
// Slot storage: length and descriptor memories, one write and one registered read port.
`timescale 1ns / 1ps

module srb_slot_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          len_we,
  input  logic          desc_we,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_len,
  input  logic [31:0]   wr_desc,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_len,
  output logic [31:0]   rd_desc
);

  logic [15:0] len_mem  [DEPTH];
  logic [31:0] desc_mem [DEPTH];

  // length store
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[wr_addr] <= wr_len;
    end
    rd_len <= len_mem[rd_addr];
  end

  // descriptor store, contents undefined until written
  always_ff @(posedge clk) begin
    if (desc_we) begin
      desc_mem[wr_addr] <= wr_desc;
    end
    rd_desc <= desc_mem[rd_addr];
  end

endmodule

[sv/sequence_reorder_buffer.sv]
// Top level: receive reorder window control around the slot memories.
`timescale 1ns / 1ps

// In the cycle a request is accepted, the slot it targets is read from the
// slot memory, and in the next cycle (busy high) the slot is updated and the
// window state moves on; a new request can be accepted in the cycle after
// that. The result appears on out_rsp with out_valid high for exactly one
// cycle, in the cycle after the update cycle, and must be taken then: the
// receiver cannot stall. Every request gives exactly one result. After reset
// the block sweeps all DEPTH length slots to empty, one per cycle, and holds
// busy high until the sweep is done.
module sequence_reorder_buffer #(
  parameter int DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  srb_pkg::srb_in_t  in_req,
  output logic            out_valid,
  output srb_pkg::srb_out_t out_rsp
);
  import srb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A  = (AW + 1)'(DEPTH);
  localparam logic [CW:0]   DEPTH_C  = (CW + 1)'(DEPTH);
  localparam logic [31:0]   DEPTH_32 = 32'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // circular slot index: (head + k) mod DEPTH, k < DEPTH
  function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                            input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, k};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  // window state
  logic [31:0]   first_seq_r, first_seq_nxt;
  logic [31:0]   last_seq_r, last_seq_nxt;
  logic [CW-1:0] msg_count_r, msg_count_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          fatal_r, fatal_nxt;

  // request in flight
  logic          busy_r;
  srb_in_t       req_r;
  logic [31:0]   dist_r;
  logic [31:0]   off_r;

  // reset clearing sweep
  logic          clr_active_r;
  logic [AW-1:0] clr_idx_r;

  // result register
  logic          out_valid_r;
  srb_out_t      out_rsp_r, rsp_nxt;

  // memory ports
  logic          len_we, desc_we;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_len, rd_len;
  logic [31:0]   rd_desc;
  logic          ex_len_we, ex_desc_we;
  logic [AW-1:0] ex_addr;
  logic [15:0]   ex_len;

  logic          accept;
  logic [31:0]   acc_off;

  assign busy    = busy_r | clr_active_r;
  assign accept  = start & ~busy;
  assign acc_off = in_req.seq_number - first_seq_r;

  // slot read issued on the accept edge
  always_comb begin
    if (in_req.operation == OP_GET) begin
      rd_addr = head_r;
    end else begin
      rd_addr = slot_at(head_r, acc_off[AW-1:0]);
    end
  end

  // execute: decide and update using the slot read back
  logic          newer;
  logic          too_far;
  logic [CW:0]   span;
  logic          full;
  logic [CW:0]   new_pos;
  logic [CW-1:0] grown;

  always_comb begin
    newer   = (dist_r != 32'd0) && !dist_r[31];
    too_far = dist_r >= DEPTH_32;
    span    = {1'b0, msg_count_r} + {1'b0, dist_r[CW-1:0]};
    full    = too_far || (span >= DEPTH_C);
    new_pos = span - (CW + 1)'(1);
    grown   = span[CW-1:0];

    first_seq_nxt = first_seq_r;
    last_seq_nxt  = last_seq_r;
    msg_count_nxt = msg_count_r;
    head_nxt      = head_r;
    fatal_nxt     = fatal_r;
    ex_len_we     = 1'b0;
    ex_desc_we    = 1'b0;
    ex_addr       = slot_at(head_r, off_r[AW-1:0]);
    ex_len        = req_r.in_length;
    rsp_nxt       = '0;
    rsp_nxt.status = ST_OK;

    if (busy_r) begin
      case (req_r.operation)
        OP_FATAL: begin
          fatal_nxt           = 1'b1;
          rsp_nxt.wake_reader = 1'b1;
        end
        OP_PUT: begin
          if (fatal_r) begin
            rsp_nxt.status = ST_FATAL;
          end else if (newer) begin
            // extend the window; skipped slots are already empty
            if (full) begin
              rsp_nxt.status = ST_FULL;
            end else begin
              rsp_nxt.wake_reader = (msg_count_r == '0) && (dist_r == 32'd1);
              ex_addr       = slot_at(head_r, new_pos[AW-1:0]);
              ex_len_we     = 1'b1;
              ex_desc_we    = 1'b1;
              msg_count_nxt = grown;
              last_seq_nxt  = req_r.seq_number;
              first_seq_nxt = req_r.seq_number - 32'(grown) + 32'd1;
            end
          end else if ((msg_count_r == '0) || (off_r >= 32'(msg_count_r))) begin
            rsp_nxt.status = ST_STALE;
          end else if (rd_len != 16'd0) begin
            // slot already holds a message
            rsp_nxt.status = ST_STALE;
          end else begin
            ex_len_we           = 1'b1;
            ex_desc_we          = 1'b1;
            rsp_nxt.wake_reader = (off_r == 32'd0);
          end
        end
        OP_GET: begin
          if (fatal_r) begin
            rsp_nxt.status = ST_FATAL;
          end else if ((msg_count_r == '0) || (rd_len == 16'd0)) begin
            rsp_nxt.status = ST_NOT_READY;
          end else begin
            // deliver head and clear its slot
            rsp_nxt.out_length     = rd_len;
            rsp_nxt.out_descriptor = rd_desc;
            rsp_nxt.out_seq        = first_seq_r;
            ex_addr       = head_r;
            ex_len        = 16'd0;
            ex_len_we     = 1'b1;
            head_nxt      = slot_at(head_r, AW'(1));
            msg_count_nxt = msg_count_r - CW'(1);
            if (msg_count_r != CW'(1)) begin
              first_seq_nxt = first_seq_r + 32'd1;
            end
          end
        end
        default: begin
          // no operation
        end
      endcase
    end
  end

  // write port shared between the clearing sweep and execute
  always_comb begin
    if (clr_active_r) begin
      len_we  = 1'b1;
      desc_we = 1'b0;
      wr_addr = clr_idx_r;
      wr_len  = 16'd0;
    end else begin
      len_we  = ex_len_we;
      desc_we = ex_desc_we;
      wr_addr = ex_addr;
      wr_len  = ex_len;
    end
  end

  srb_slot_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slot_mem (
    .clk     (clk),
    .len_we  (len_we),
    .desc_we (desc_we),
    .wr_addr (wr_addr),
    .wr_len  (wr_len),
    .wr_desc (req_r.in_descriptor),
    .rd_addr (rd_addr),
    .rd_len  (rd_len),
    .rd_desc (rd_desc)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seq_r  <= 32'd0;
      last_seq_r   <= 32'hFFFF_FFFF;
      msg_count_r  <= '0;
      head_r       <= '0;
      fatal_r      <= 1'b0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else begin
      first_seq_r <= first_seq_nxt;
      last_seq_r  <= last_seq_nxt;
      msg_count_r <= msg_count_nxt;
      head_r      <= head_nxt;
      fatal_r     <= fatal_nxt;
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (clr_active_r) begin
        if (clr_idx_r == LAST_IDX) begin
          clr_active_r <= 1'b0;
        end else begin
          clr_idx_r <= clr_idx_r + AW'(1);
        end
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req;
      dist_r <= in_req.seq_number - last_seq_r;
      off_r  <= acc_off;
    end
    if (busy_r) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

[tb/tb_sequence_reorder_buffer.sv]
// Self-checking testbench for the sequence reorder buffer: directed and random requests.
`timescale 1ns / 1ps

module tb_sequence_reorder_buffer;
  import srb_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int PHASE_ITEMS = 550;
  localparam int LIMIT       = 200000;

  // Window predictor and store of expected responses
  class window_scoreboard;
    logic [31:0]       first_seq;
    logic [31:0]       last_seq;
    logic [SLOT_W:0]   msg_count;
    logic [SLOT_W-1:0] head_slot;
    bit                fatal_seen;
    logic [15:0]       slot_len [DEPTH];
    logic [31:0]       slot_desc [DEPTH];
    srb_out_t          expected_rsp [$];
    int                n_requests, n_checked, n_errors;
    int                n_delivered, n_full, n_stale, n_not_ready, n_fatal;

    function new();
      first_seq  = '0;
      last_seq   = '1;
      msg_count  = '0;
      head_slot  = '0;
      fatal_seen = 1'b0;
      foreach (slot_len[i]) begin
        slot_len[i]  = '0;
        slot_desc[i] = '0;
      end
    endfunction

    // a is newer than b in serial arithmetic mod 2^32
    function bit is_newer(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return (d != 0) && !d[31];
    endfunction

    function logic [SLOT_W-1:0] slot_of(logic [31:0] k);
      return head_slot + k[SLOT_W-1:0];
    endfunction

    // Note one accepted request and queue the response it must give
    function void note_request(srb_in_t req);
      srb_out_t          e;
      logic [31:0]       jump;
      logic [31:0]       off;
      logic [SLOT_W-1:0] k;
      int unsigned       i;
      e = '0;
      n_requests++;
      if (req.operation == OP_FATAL) begin
        fatal_seen    = 1'b1;
        e.wake_reader = 1'b1;
      end else if (req.operation == OP_NOP) begin
        // no effect
      end else if (fatal_seen) begin
        e.status = ST_FATAL;
      end else if (req.operation == OP_PUT) begin
        if (is_newer(req.seq_number, last_seq)) begin
          jump = req.seq_number - last_seq;
          if (jump >= DEPTH || 32'(msg_count) + jump >= DEPTH) begin
            e.status = ST_FULL;
          end else begin
            if (msg_count == 0 && jump == 1) e.wake_reader = 1'b1;
            // skipped numbers open as empty slots
            for (i = 1; i < jump; i++) begin
              slot_len[slot_of(32'(msg_count))] = '0;
              msg_count++;
            end
            k            = slot_of(32'(msg_count));
            slot_len[k]  = req.in_length;
            slot_desc[k] = req.in_descriptor;
            msg_count++;
            last_seq  = req.seq_number;
            first_seq = req.seq_number - 32'(msg_count) + 32'd1;
          end
        end else begin
          off = req.seq_number - first_seq;
          if (msg_count == 0 || is_newer(first_seq, req.seq_number) ||
              off >= 32'(msg_count)) begin
            e.status = ST_STALE;
          end else begin
            k = slot_of(off);
            if (slot_len[k] != 0) begin
              e.status = ST_STALE;
            end else begin
              if (off == 0) e.wake_reader = 1'b1;
              slot_len[k]  = req.in_length;
              slot_desc[k] = req.in_descriptor;
            end
          end
        end
      end else begin
        // get from the head of the window
        k = head_slot;
        if (msg_count == 0 || slot_len[k] == 0) begin
          e.status = ST_NOT_READY;
        end else begin
          e.out_length     = slot_len[k];
          e.out_descriptor = slot_desc[k];
          e.out_seq        = first_seq;
          slot_len[k]      = '0;
          head_slot++;
          msg_count--;
          if (msg_count != 0) first_seq++;
        end
      end
      case (e.status)
        ST_OK:        if (e.out_length != 0) n_delivered++;
        ST_FULL:      n_full++;
        ST_STALE:     n_stale++;
        ST_NOT_READY: n_not_ready++;
        ST_FATAL:     n_fatal++;
        default:      ;
      endcase
      expected_rsp.insert(expected_rsp.size(), e);
    endfunction

    // Compare one response against the oldest expectation
    function void check_result(srb_out_t got);
      srb_out_t e;
      if (expected_rsp.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected response: status=%0d wake=%0b len=%h desc=%h seq=%h",
                   got.status, got.wake_reader, got.out_length, got.out_descriptor,
                   got.out_seq);
        return;
      end
      e = expected_rsp[0];
      expected_rsp.delete(0);
      n_checked++;
      if (got.status !== e.status || got.wake_reader !== e.wake_reader ||
          got.out_length !== e.out_length || got.out_descriptor !== e.out_descriptor ||
          got.out_seq !== e.out_seq) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("mismatch on response %0d: expected status=%0d wake=%0b len=%h desc=%h seq=%h",
                   n_checked, e.status, e.wake_reader, e.out_length, e.out_descriptor,
                   e.out_seq);
          $display("  got status=%0d wake=%0b len=%h desc=%h seq=%h",
                   got.status, got.wake_reader, got.out_length, got.out_descriptor,
                   got.out_seq);
        end
      end
    endfunction
  endclass

  logic     clk    = 1'b0;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  srb_in_t  in_req = '0;
  logic     busy;
  logic     out_valid;
  srb_out_t out_rsp;

  window_scoreboard sb = new();
  int idle_pct = 0;
  int cycles   = 0;

  sequence_reorder_buffer #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, allows for the slot clearing sweep after reset
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Responses cannot be held off: take each one in its strobe cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_rsp);
  end

  function automatic srb_in_t make_req(logic [1:0] op, logic [31:0] seq,
                                       logic [15:0] len, logic [31:0] desc);
    srb_in_t r;
    r.operation     = op;
    r.seq_number    = seq;
    r.in_length     = len;
    r.in_descriptor = desc;
    return r;
  endfunction

  function automatic logic [15:0] any_len();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  // Random request shaped around the current window
  function automatic srb_in_t random_req(int get_pct);
    srb_in_t     r;
    int unsigned p;
    int unsigned q;
    r.operation     = OP_PUT;
    r.seq_number    = sb.last_seq + 32'd1;
    r.in_length     = any_len();
    r.in_descriptor = $urandom();
    p = $urandom_range(99);
    q = $urandom_range(99);
    if (p < get_pct) begin
      r.operation  = OP_GET;
      r.seq_number = $urandom();
    end else if (p < 94) begin
      if (q < 40)      r.seq_number = sb.last_seq + 32'd1;
      else if (q < 60) r.seq_number = sb.last_seq + $urandom_range(2, 8);
      else if (q < 65) r.seq_number = sb.last_seq + $urandom_range(9, 1100);
      else if (q < 82) r.seq_number = sb.first_seq + $urandom_range(0, 32'(sb.msg_count));
      else if (q < 92) r.seq_number = sb.first_seq;
      else             r.seq_number = sb.first_seq - $urandom_range(1, 50);
    end else if (p < 97) begin
      r.seq_number = $urandom();
    end else if (p < 99) begin
      r.operation  = OP_NOP;
      r.seq_number = $urandom();
    end else begin
      r.seq_number = sb.last_seq + 32'h8000_0000 + $urandom_range(0, 3);
    end
    return r;
  endfunction

  // Present one request and hold it until the block takes it
  task automatic issue_request(input srb_in_t req);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(req);
  endtask

  task automatic run_phase(input int pct);
    int n;
    int get_pct;
    idle_pct = pct;
    get_pct  = 35;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      // switch at random between filling, draining and balanced stretches
      if (n % 80 == 0) begin
        case ($urandom_range(2))
          0:       get_pct = 10;
          1:       get_pct = 55;
          default: get_pct = 35;
        endcase
      end
      issue_request(random_req(get_pct));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty window, in-order, gaps, refills, stale and full cases
    issue_request(make_req(OP_GET, $urandom(), 16'h0000, $urandom()));
    issue_request(make_req(OP_PUT, 32'd0, 16'hFFFF, 32'hFFFF_FFFF));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_PUT, 32'd0, 16'd7, $urandom()));
    issue_request(make_req(OP_PUT, 32'd1, 16'h0000, 32'h0000_0000));
    issue_request(make_req(OP_GET, 32'd1, 16'h0000, 32'd0));
    issue_request(make_req(OP_PUT, 32'd1, 16'd5, $urandom()));
    issue_request(make_req(OP_PUT, 32'd1, 16'd9, $urandom()));
    issue_request(make_req(OP_PUT, 32'd5, 16'd1, $urandom()));
    issue_request(make_req(OP_PUT, 32'd3, any_len() | 16'd1, $urandom()));
    issue_request(make_req(OP_PUT, 32'd0, 16'd3, $urandom()));
    issue_request(make_req(OP_PUT, 32'h8000_0005, 16'd3, $urandom()));
    issue_request(make_req(OP_PUT, 32'd5 + DEPTH, 16'd3, $urandom()));
    issue_request(make_req(OP_NOP, $urandom(), 16'($urandom()), $urandom()));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_PUT, 32'd2, 16'd1, 32'h0000_0000));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_PUT, 32'd4, 16'd2, $urandom()));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    // widest legal jump, then one more number overflows the window
    issue_request(make_req(OP_PUT, 32'd5 + DEPTH - 1, 16'd4, $urandom()));
    issue_request(make_req(OP_PUT, 32'd5 + DEPTH, 16'd4, $urandom()));

    // Random: busy sender, very sparse sender, then back to back
    run_phase(35);
    run_phase(86);
    run_phase(0);

    // Fatal error latches for good, so it comes last
    issue_request(make_req(OP_FATAL, $urandom(), 16'($urandom()), $urandom()));
    issue_request(make_req(OP_PUT, sb.last_seq + 32'd1, 16'd1, $urandom()));
    issue_request(make_req(OP_GET, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_FATAL, 32'd0, 16'h0000, 32'd0));
    issue_request(make_req(OP_NOP, 32'd0, 16'h0000, 32'd0));
    start <= 1'b0;

    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests, %0d responses checked: %0d deliveries, %0d not ready",
             sb.n_requests, sb.n_checked, sb.n_delivered, sb.n_not_ready);
    $display("  %0d stale, %0d window full, %0d fatal replies, %0d errors",
             sb.n_stale, sb.n_full, sb.n_fatal, sb.n_errors);
    if (sb.n_errors == 0 && sb.expected_rsp.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
